>>> src/deq_pkg.sv
// Package for the double-ended queue unit: sizes, command and status codes,
// and the packed request and response transaction types. No dependencies.
package deq_pkg;

  // Store depth; index arithmetic wraps modulo a power of two.
  localparam int unsigned DEPTH = 1024;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_TWO  = IDX_W'(2);

  // Command codes (codes above CMD_CLEAR behave as a query)
  localparam logic [2:0] CMD_QUERY      = 3'd0;
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd2;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [2:0] CMD_POP_BACK   = 3'd4;
  localparam logic [2:0] CMD_CLEAR      = 3'd5;

  // Status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [CNT_W-1:0]   length;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
  } rsp_t;

endpackage

>>> src/double_ended_queue_unit.sv
// Double-ended queue unit: circular word store with head and count registers.
// Depends on deq_pkg.
//
// Bounded deque of DEPTH signed 32-bit words. Every request transaction
// (query, push front, push back, pop front, pop back, clear) returns exactly
// one response transaction carrying a status, the length after the command
// and the front and back words (zero when empty). Full pushes and empty pops
// are rejected with a status code and leave the queue untouched. The words
// live in a synchronous single-port-write, single-port-read RAM with a
// registered read; the front and back words are kept in registers so that
// queries and pushes need no RAM read. Throughput: one transaction per cycle
// for query, push, clear and rejected commands unless the response stalls; a
// pop that leaves the queue non-empty holds off the next request until the
// new end word is read from the RAM. A request is taken whenever no RAM read
// is outstanding and the response register is empty or being emptied in the same cycle.
// The RAM needs no clearing pass after reset: only written entries are read.
module double_ended_queue_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  deq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output deq_pkg::rsp_t rsp
);
  import deq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t state, state_next;

  // Queue bookkeeping
  logic [IDX_W-1:0]   head, head_next;
  logic [CNT_W-1:0]   count, count_next;
  logic signed [31:0] front_word, front_word_next;
  logic signed [31:0] back_word, back_word_next;

  // Word store
  logic signed [31:0] mem [DEPTH];
  logic               mem_we, mem_re;
  logic [IDX_W-1:0]   mem_waddr, mem_raddr;
  logic signed [31:0] mem_rdata;

  logic       accept;
  logic       full, empty;
  logic [1:0] status;
  logic       rd_front, rd_front_next;   // pending read refills the front word

  assign req_stall = !((state == S_IDLE) && (!rsp_valid || !rsp_stall));
  assign accept    = req_valid && !req_stall;
  assign full      = (count == CNT_FULL);
  assign empty     = (count == '0);

  // Command decode
  always_comb begin
    head_next       = head;
    count_next      = count;
    front_word_next = front_word;
    back_word_next  = back_word;
    status          = ST_DONE;
    mem_we          = 1'b0;
    mem_waddr       = head;
    mem_re          = 1'b0;
    mem_raddr       = head;
    rd_front_next   = rd_front;
    unique case (req.command)
      CMD_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          head_next       = head - IDX_ONE;
          count_next      = count + CNT_W'(1);
          mem_we          = 1'b1;
          mem_waddr       = head - IDX_ONE;
          front_word_next = req.value;
          if (empty) begin
            back_word_next = req.value;
          end
        end
      end
      CMD_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          count_next     = count + CNT_W'(1);
          mem_we         = 1'b1;
          mem_waddr      = head + count[IDX_W-1:0];
          back_word_next = req.value;
          if (empty) begin
            front_word_next = req.value;
          end
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          head_next  = head + IDX_ONE;
          count_next = count - CNT_W'(1);
          if (count == CNT_W'(1)) begin
            front_word_next = '0;
            back_word_next  = '0;
          end else begin
            mem_re        = 1'b1;
            mem_raddr     = head + IDX_ONE;
            rd_front_next = 1'b1;
          end
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          count_next = count - CNT_W'(1);
          if (count == CNT_W'(1)) begin
            front_word_next = '0;
            back_word_next  = '0;
          end else begin
            mem_re        = 1'b1;
            mem_raddr     = head + count[IDX_W-1:0] - IDX_TWO;
            rd_front_next = 1'b0;
          end
        end
      end
      CMD_CLEAR: begin
        head_next       = '0;
        count_next      = '0;
        front_word_next = '0;
        back_word_next  = '0;
      end
      default: begin
        // query and unused codes: nothing changes
      end
    endcase
    if (!accept) begin
      mem_we = 1'b0;
      mem_re = 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (mem_re) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Word store: one write and one registered read per cycle. Pops never
  // write, so a read never meets a write to the same entry in one cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= req.value;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      count      <= '0;
      front_word <= '0;
      back_word  <= '0;
      rsp_valid  <= 1'b0;
      rd_front   <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        head       <= head_next;
        count      <= count_next;
        front_word <= front_word_next;
        back_word  <= back_word_next;
        rd_front   <= rd_front_next;
        rsp_valid  <= !mem_re;
      end else if (state == S_READ) begin
        // refill the end word that the pop exposed
        if (rd_front) begin
          front_word <= mem_rdata;
        end else begin
          back_word <= mem_rdata;
        end
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Response register; the refilled word lands in S_READ
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status      <= status;
      rsp.length      <= count_next;
      rsp.front_value <= front_word_next;
      rsp.back_value  <= back_word_next;
    end else if (state == S_READ) begin
      if (rd_front) begin
        rsp.front_value <= mem_rdata;
      end else begin
        rsp.back_value <= mem_rdata;
      end
    end
  end

`ifndef ASSERT_OFF
  // An outstanding RAM read always has a free response register.
  a_read_rsp_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> !rsp_valid)
    else $error("response register busy during RAM read");

  // A RAM read is followed by the refill cycle.
  a_read_refill: assert property (@(posedge clk) disable iff (rst)
    mem_re |=> (state == S_READ))
    else $error("RAM read without refill cycle");

  // An empty queue shows zero end words once no refill is pending.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (empty && state == S_IDLE) |-> (front_word == '0 && back_word == '0))
    else $error("empty queue with non-zero end words");

  // The count never exceeds the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("entry count beyond depth");
`endif

endmodule
